/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the interpreter core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk that is switched off while rst is high.
`define C8_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on clk that also holds across reset.
`define C8_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/c8core_pkg.sv */
// Package with the types, codes and helper functions of the interpreter core.
`timescale 1ns / 1ps

package c8core_pkg;

  localparam int DEF_SCREEN_WIDTH  = 64;
  localparam int DEF_SCREEN_HEIGHT = 32;
  localparam int DEF_MEMORY_BYTES  = 4096;

  // Widest framebuffer byte address over the supported screen sizes (128 x 64).
  localparam int FB_ADDR_W = 10;

  localparam logic [11:0] PC_RESET    = 12'h200;
  localparam logic [11:0] OP_CLS_ARG  = 12'h0E0;
  localparam logic [7:0]  PIX_MSB     = 8'h80;
  localparam logic [3:0]  VF_IDX      = 4'hF;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_EXEC  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [3:0] OP_SYS = 4'h0;
  localparam logic [3:0] OP_JP  = 4'h1;
  localparam logic [3:0] OP_LD  = 4'h6;
  localparam logic [3:0] OP_ADD = 4'h7;
  localparam logic [3:0] OP_LDI = 4'hA;
  localparam logic [3:0] OP_DRW = 4'hD;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH_LO,
    ST_EXEC,
    ST_CLEAR,
    ST_DRAW_Y,
    ST_ROW_RD,
    ST_ROW_BASE,
    ST_PIXEL,
    ST_DRAIN,
    ST_DISP,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic        en;
    logic [11:0] addr;
    logic [7:0]  data;
  } pm_wr_t;

  typedef struct packed {
    logic                 en;
    logic                 rmw;
    logic [FB_ADDR_W-1:0] addr;
    logic [7:0]           mask;
  } fb_req_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } fb_stat_t;

  // Reduces a 12-bit address into a memory of m bytes, m at least a quarter of 4096.
  function automatic logic [11:0] mem_slot(input logic [11:0] a, input logic [12:0] m);
    logic [13:0] av;
    logic [13:0] m1;
    logic [13:0] m2;
    logic [13:0] m3;
    av = {2'b00, a};
    m1 = {1'b0, m};
    m2 = m1 << 1;
    m3 = m1 + m2;
    if (av >= m3) begin
      av = av - m3;
    end else if (av >= m2) begin
      av = av - m2;
    end else if (av >= m1) begin
      av = av - m1;
    end
    return av[11:0];
  endfunction

  // Remainder of a value below 512 by a modulus of 8 or more, by restoring steps.
  function automatic logic [8:0] mod_small(input logic [8:0] v, input logic [7:0] m);
    logic [14:0] r;
    logic [14:0] d;
    r = {6'b0, v};
    for (int k = 5; k >= 0; k--) begin
      d = {7'b0, m} << k;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[8:0];
  endfunction

endpackage

/* rtl/c8core_pmem.sv */
// Program memory with a zeroing sweep after reset.
`timescale 1ns / 1ps

module c8core_pmem import c8core_pkg::*; #(
  parameter int MEMORY_BYTES = DEF_MEMORY_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  pm_wr_t      wr,
  input  logic [11:0] rd_addr,
  output logic [7:0]  rd_data,
  output logic        busy
);

  localparam int AW = $clog2(MEMORY_BYTES);

  logic [7:0]    mem [MEMORY_BYTES];
  logic          clearing;
  logic [AW-1:0] clr_idx;
  logic [11:0]   wslot;
  logic [11:0]   rslot;

  assign wslot = mem_slot(wr.addr, 13'(MEMORY_BYTES));
  assign rslot = mem_slot(rd_addr, 13'(MEMORY_BYTES));
  assign busy  = clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == AW'(MEMORY_BYTES - 1)) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= 8'h00;
    end else if (wr.en) begin
      mem[wslot[AW-1:0]] <= wr.data;
    end
    rd_data <= mem[rslot[AW-1:0]];
  end

endmodule

/* rtl/c8core_fbuf.sv */
// Framebuffer memory with pixel read-modify-write, write forwarding and a clear sweep.
`timescale 1ns / 1ps

module c8core_fbuf import c8core_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic     clk,
  input  logic     rst,
  input  fb_req_t  req,
  input  logic     clr_start,
  output fb_stat_t stat,
  output logic [7:0] rd_data
);

  localparam int FB_BYTES = (SCREEN_WIDTH * SCREEN_HEIGHT + 7) / 8;
  localparam int FB_AW    = $clog2(FB_BYTES);

  logic [7:0]       mem [FB_BYTES];
  logic [7:0]       mem_q;
  logic             clearing;
  logic [FB_AW-1:0] clr_idx;

  logic             s1_valid;
  logic             s1_rmw;
  logic [FB_AW-1:0] s1_addr;
  logic [7:0]       s1_mask;

  logic             w_valid;
  logic [FB_AW-1:0] w_addr;
  logic [7:0]       w_data;

  logic [7:0]       cur;
  logic [7:0]       new_byte;
  logic             do_wr;

  // The read issued in the same cycle as the previous write missed that write.
  assign cur      = (w_valid && (w_addr == s1_addr)) ? w_data : mem_q;
  assign new_byte = cur ^ s1_mask;
  assign do_wr    = s1_valid && s1_rmw;
  assign rd_data  = cur;
  assign stat.hit  = do_wr && ((cur & s1_mask) != 8'h00);
  assign stat.busy = clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
      s1_valid <= 1'b0;
      w_valid  <= 1'b0;
    end else begin
      if (clr_start) begin
        clearing <= 1'b1;
        clr_idx  <= '0;
      end else if (clearing) begin
        if (clr_idx == FB_AW'(FB_BYTES - 1)) begin
          clearing <= 1'b0;
        end
        clr_idx <= clr_idx + 1'b1;
      end
      s1_valid <= req.en;
      w_valid  <= do_wr;
    end
  end

  always_ff @(posedge clk) begin
    s1_rmw  <= req.rmw;
    s1_addr <= req.addr[FB_AW-1:0];
    s1_mask <= req.mask;
    w_addr  <= s1_addr;
    w_data  <= new_byte;
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= 8'h00;
    end else if (do_wr) begin
      mem[s1_addr] <= new_byte;
    end
    if (req.en) begin
      mem_q <= mem[req.addr[FB_AW-1:0]];
    end
  end

endmodule

/* rtl/chip8_core_subset_with_sprite_draw_core.sv */
// Top level of the interpreter core: fetch/execute sequencer, registers and output stage.
// A memory write, an unused kind or an out-of-range display read goes straight to the
// result; an in-range display read passes ST_DISP; an instruction is fetched, then run in
// ST_EXEC; clear screen waits for the sweep; a draw takes each sprite row through ST_ROW_RD,
// ST_ROW_BASE and ST_PIXEL. One item is in work at a time; the next is taken once its result
// sits in the output stage. Reset zeroes both memories in a sweep.
`timescale 1ns / 1ps

module chip8_core_subset_with_sprite_draw_core import c8core_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int MEMORY_BYTES  = DEF_MEMORY_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [11:0] address,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] program_counter_out,
  output logic [15:0] fetched_word,
  output logic [7:0]  flag_register,
  output logic [7:0]  display_byte,
  output logic        unknown_op
);

  localparam int FB_BYTES = (SCREEN_WIDTH * SCREEN_HEIGHT + 7) / 8;
  localparam int PIX_W    = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT);
  localparam int SY_W     = $clog2(SCREEN_HEIGHT);
  localparam int SX_W     = $clog2(SCREEN_WIDTH + 8);

  state_t state;
  state_t state_next;

  // Architectural state kept in flip-flops: program counter, index and the 16 data registers.
  logic [11:0] pc;
  logic [11:0] index;
  logic [7:0]  vreg [16];

  // Per-item working registers.
  logic [7:0]       hi_q;
  logic [15:0]      word_q;
  logic             unk_q;
  logic [7:0]       dbyte_q;
  logic [SX_W-1:0]  x0m;
  logic [7:0]       y0;
  logic [3:0]       row;
  logic [2:0]       col;
  logic [SY_W-1:0]  sy_q;
  logic [PIX_W-1:0] row_base;
  logic [7:0]       bits_q;

  // Memory interfaces.
  pm_wr_t      pm_wr;
  logic [11:0] pm_rd_addr;
  logic [7:0]  pm_rdata;
  logic        pm_busy;
  fb_req_t     fb_req;
  logic        fb_clr;
  fb_stat_t    fb_stat;
  logic [7:0]  fb_rdata;

  // Combinational controls.
  logic        accept;
  logic        out_free;
  logic        out_load;
  logic [15:0] word_c;
  logic [3:0]  reg_sel;
  logic [7:0]  vreg_rd;
  logic        vr_we;
  logic [3:0]  vr_idx;
  logic [7:0]  vr_wd;
  logic        disp_in_range;
  logic        last_row;

  // Pixel address for the current sprite column.
  logic [SX_W-1:0]  sx_sum;
  logic [SX_W-1:0]  sx;
  logic [PIX_W-1:0] pix;

  c8core_pmem #(
    .MEMORY_BYTES(MEMORY_BYTES)
  ) u_pmem (
    .clk     (clk),
    .rst     (rst),
    .wr      (pm_wr),
    .rd_addr (pm_rd_addr),
    .rd_data (pm_rdata),
    .busy    (pm_busy)
  );

  c8core_fbuf #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_fbuf (
    .clk       (clk),
    .rst       (rst),
    .req       (fb_req),
    .clr_start (fb_clr),
    .stat      (fb_stat),
    .rd_data   (fb_rdata)
  );

  // The input side is closed in reset, while an item is in work or while either memory is being swept.
  assign in_stall      = rst || (state != ST_IDLE) || pm_busy || fb_stat.busy;
  assign accept        = in_valid && !in_stall;
  assign out_free      = !out_valid || !out_stall;
  assign word_c        = {hi_q, pm_rdata};
  assign vreg_rd       = vreg[reg_sel];
  assign disp_in_range = address < 12'(FB_BYTES);
  assign last_row      = (row == (word_q[3:0] - 4'd1));

  // The sprite is at most 8 wide, so one conditional subtract wraps the column.
  assign sx_sum = x0m + SX_W'(col);
  assign sx     = (sx_sum >= SX_W'(SCREEN_WIDTH)) ? (sx_sum - SX_W'(SCREEN_WIDTH)) : sx_sum;
  assign pix    = row_base + PIX_W'(sx);

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_EXEC: state_next = ST_FETCH_LO;
            KIND_READ: state_next = disp_in_range ? ST_DISP : ST_RESULT;
            default:   state_next = ST_RESULT;
          endcase
        end
      end
      ST_FETCH_LO: state_next = ST_EXEC;
      ST_EXEC: begin
        case (word_c[15:12])
          OP_SYS:  state_next = (word_c[11:0] == OP_CLS_ARG) ? ST_CLEAR : ST_RESULT;
          OP_DRW:  state_next = ST_DRAW_Y;
          default: state_next = ST_RESULT;
        endcase
      end
      ST_CLEAR:    state_next = fb_stat.busy ? ST_CLEAR : ST_RESULT;
      ST_DRAW_Y:   state_next = (word_q[3:0] == 4'd0) ? ST_RESULT : ST_ROW_RD;
      ST_ROW_RD:   state_next = ST_ROW_BASE;
      ST_ROW_BASE: state_next = ST_PIXEL;
      ST_PIXEL: begin
        if (col == 3'd7) begin
          state_next = last_row ? ST_DRAIN : ST_ROW_RD;
        end
      end
      ST_DRAIN:  state_next = ST_RESULT;
      ST_DISP:   state_next = ST_RESULT;
      ST_RESULT: state_next = out_free ? ST_IDLE : ST_RESULT;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Output decode of the sequencer: memory ports, register file port, result load.
  always_comb begin
    pm_wr.en   = accept && (kind == KIND_WRITE);
    pm_wr.addr = address;
    pm_wr.data = write_data;
    pm_rd_addr = pc;
    fb_req.en   = 1'b0;
    fb_req.rmw  = 1'b0;
    fb_req.addr = FB_ADDR_W'(pix >> 3);
    fb_req.mask = PIX_MSB >> pix[2:0];
    fb_clr   = 1'b0;
    reg_sel  = word_q[11:8];
    vr_we    = 1'b0;
    vr_idx   = word_c[11:8];
    vr_wd    = word_c[7:0];
    out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        // Display reads go out at accept so the byte is back in the next cycle.
        fb_req.en   = accept && (kind == KIND_READ) && disp_in_range;
        fb_req.addr = address[FB_ADDR_W-1:0];
      end
      ST_FETCH_LO: begin
        pm_rd_addr = pc + 12'd1;
      end
      ST_EXEC: begin
        reg_sel = word_c[11:8];
        case (word_c[15:12])
          OP_SYS: fb_clr = (word_c[11:0] == OP_CLS_ARG);
          OP_LD:  vr_we  = 1'b1;
          OP_ADD: begin
            vr_we = 1'b1;
            vr_wd = vreg_rd + word_c[7:0];
          end
          default: ;
        endcase
      end
      ST_DRAW_Y: begin
        // The y coordinate is read in the same cycle that VF is cleared.
        reg_sel = word_q[7:4];
        vr_we   = 1'b1;
        vr_idx  = VF_IDX;
        vr_wd   = 8'h00;
      end
      ST_ROW_RD: begin
        pm_rd_addr = index + {8'h00, row};
      end
      ST_PIXEL: begin
        fb_req.en  = bits_q[3'd7 - col];
        fb_req.rmw = 1'b1;
      end
      ST_RESULT: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= PC_RESET;
      index     <= 12'h000;
      out_valid <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        vreg[i] <= 8'h00;
      end
    end else begin
      state <= state_next;
      if (vr_we) begin
        vreg[vr_idx] <= vr_wd;
      end
      // A collision reported by the framebuffer stage raises VF.
      if (fb_stat.hit) begin
        vreg[VF_IDX] <= 8'h01;
      end
      if (state == ST_EXEC) begin
        pc <= (word_c[15:12] == OP_JP) ? word_c[11:0] : (pc + 12'd2);
        if (word_c[15:12] == OP_LDI) begin
          index <= word_c[11:0];
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and the output payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      word_q  <= 16'h0000;
      unk_q   <= 1'b0;
      dbyte_q <= 8'h00;
    end
    case (state)
      ST_FETCH_LO: hi_q <= pm_rdata;
      ST_EXEC: begin
        word_q <= word_c;
        unk_q  <= !(word_c[15:12] inside {OP_SYS, OP_JP, OP_LD, OP_ADD, OP_LDI, OP_DRW});
        x0m    <= SX_W'(mod_small({1'b0, vreg_rd}, 8'(SCREEN_WIDTH)));
      end
      ST_DRAW_Y: begin
        y0  <= vreg_rd;
        row <= 4'd0;
      end
      ST_ROW_RD: begin
        sy_q <= SY_W'(mod_small({1'b0, y0} + {5'b0, row}, 8'(SCREEN_HEIGHT)));
      end
      ST_ROW_BASE: begin
        bits_q   <= pm_rdata;
        row_base <= PIX_W'(sy_q * SCREEN_WIDTH);
        col      <= 3'd0;
      end
      ST_PIXEL: begin
        col <= col + 3'd1;
        if (col == 3'd7) begin
          row <= row + 4'd1;
        end
      end
      ST_DISP: dbyte_q <= fb_rdata;
      default: ;
    endcase
    if (out_load) begin
      program_counter_out <= pc;
      fetched_word        <= word_q;
      flag_register       <= vreg[VF_IDX];
      display_byte        <= dbyte_q;
      unknown_op          <= unk_q;
    end
  end

endmodule

/* rtl/c8core_chk.sv */
// Port-level checker for the interpreter core, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module c8core_chk import c8core_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] program_counter_out,
  input logic [15:0] fetched_word,
  input logic [7:0]  flag_register,
  input logic [7:0]  display_byte,
  input logic        unknown_op
);

  logic        op_known;
  logic        is_jump;
  logic [44:0] out_payload;

  assign op_known    = fetched_word[15:12] inside {OP_SYS, OP_JP, OP_LD, OP_ADD, OP_LDI, OP_DRW};
  assign is_jump     = (fetched_word[15:12] == OP_JP);
  assign out_payload = {program_counter_out, fetched_word, flag_register, display_byte,
                        unknown_op};

  `C8_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `C8_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_payload), "stalled result changed")
  `C8_ASSERT_ALWAYS(a_rst_sweep, rst |=> in_stall, "input open right after reset")
  `C8_ASSERT(a_unknown, out_valid |-> (unknown_op == !op_known), "unknown flag disagrees")
  `C8_ASSERT(a_jump, out_valid && is_jump |-> (program_counter_out == fetched_word[11:0]), "jump")

endmodule

bind chip8_core_subset_with_sprite_draw_core c8core_chk u_c8core_chk (.*);
